FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Clock and reset are taken as clk and rst of the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: cond must hold whenever trig holds.
`define DGS_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("dgs check failed");

// Next-cycle implication: cond must hold in the cycle after trig.
`define DGS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("dgs check failed");

`endif

FILE: src/dgs_pkg.sv
// Types and constants of the discrete Gaussian sampler.
// Holds the cumulative table and fixed-point constants; no dependencies.
package dgs_pkg;

  localparam int CDT_ENTRIES = 21;
  localparam int EXP_TERMS   = 20;
  localparam int MAX_SPREAD  = 24;
  localparam int IN_W        = 272;
  localparam int OUT_W       = 32;

  localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] LOG2E_Q60 = 64'h1715_4765_2B82_FE18;
  localparam logic [63:0] LN2_Q64   = 64'hB172_17F7_D1CF_79AC;
  localparam logic [9:0]  DIV_961   = 10'd961;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CDT  = 9'b000000010,
    ST_SQ   = 9'b000000100,
    ST_LOG  = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_LN2  = 9'b000100000,
    ST_EXPM = 9'b001000000,
    ST_EXPD = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  function automatic logic [127:0] cdt_entry(input logic [4:0] idx);
    logic [127:0] v;
    case (idx)
      5'd0:  v = {64'd10894764499197476522, 64'd10804844707381617341};
      5'd1:  v = {64'd4761708367981796450,  64'd6209732027000382074};
      5'd2:  v = {64'd1476784279527800432,  64'd14108379346150813303};
      5'd3:  v = {64'd316388870594767345,   64'd17827298407763885637};
      5'd4:  v = {64'd46043503515468600,    64'd18385899657892021654};
      5'd5:  v = {64'd4503729779335039,     64'd3860889375818664979};
      5'd6:  v = {64'd294122444862326,      64'd13947176349836216550};
      5'd7:  v = {64'd12769598070895,       64'd14321894682751135119};
      5'd8:  v = {64'd367552986472,         64'd10286761328368440884};
      5'd9:  v = {64'd7001273393,           64'd2287787188970898528};
      5'd10: v = {64'd88153536,             64'd17843977990435837663};
      5'd11: v = {64'd733119,               64'd12174894787802692461};
      5'd12: v = {64'd4024,                 64'd18067426722645776197};
      5'd13: v = {64'd14,                   64'd10764017821655913055};
      5'd14: v = {64'd0,                    64'd643125733022530080};
      5'd15: v = {64'd0,                    64'd1014291014134832};
      5'd16: v = {64'd0,                    64'd1055215183460};
      5'd17: v = {64'd0,                    64'd724109373};
      5'd18: v = {64'd0,                    64'd327744};
      5'd19: v = {64'd0,                    64'd98};
      default: v = 128'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/dgs_mul.sv
// Shared 64x64 multiplier built from one 32x32 multiplier over four passes.
// Standalone; the top-level sequencer drives go and waits for done.
module dgs_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);
  logic [63:0]  ra, rb;
  logic [63:0]  preg;
  logic [1:0]   psh;
  logic         pv;
  logic [2:0]   cnt;
  logic         busy;
  logic [31:0]  ah, bh;

  assign ah = cnt[0] ? ra[63:32] : ra[31:0];
  assign bh = cnt[1] ? rb[63:32] : rb[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        pv   <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        pv <= (cnt < 3'd4);
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ra   <= a;
      rb   <= b;
      prod <= '0;
    end else begin
      preg <= 64'(ah) * 64'(bh);
      psh  <= 2'(cnt[0]) + 2'(cnt[1]);
      // accumulate the product issued last cycle at its 32-bit column
      if (pv) prod <= prod + (128'(preg) << {psh, 5'd0});
    end
  end
endmodule

FILE: src/dgs_div.sv
// Shared restoring divider by a small divisor, four quotient bits a cycle.
// Dividend enters msb-aligned; the low 64 quotient bits are returned.
module dgs_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [127:0] dividend,
  input  logic [9:0]   divisor,
  input  logic [5:0]   steps,
  output logic [63:0]  quot,
  output logic         done
);
  logic [127:0] sr, sr_next;
  logic [9:0]   rem, rem_next, dv;
  logic [5:0]   cnt;
  logic         busy;

  always_comb begin
    logic [10:0] t;
    sr_next  = sr;
    rem_next = rem;
    for (int i = 0; i < 4; i++) begin
      t       = {rem_next, sr_next[127]};
      sr_next = {sr_next[126:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        rem_next   = 10'(t - {1'b0, dv});
        sr_next[0] = 1'b1;
      end else begin
        rem_next = t[9:0];
      end
    end
  end

  assign quot = sr[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sr  <= dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (busy) begin
      sr  <= sr_next;
      rem <= rem_next;
    end
  end
endmodule

FILE: src/discrete_gaussian_sampler.sv
// Discrete Gaussian sampler: one rejection attempt per request.
// Uses dgs_pkg, dgs_mul and dgs_div.
//
// Usage: write log2_spread on cfg_we/cfg_wdata while idle (values above 24
// act as 24). Each request on s_* carries offset, sign bit, 128 table bits,
// the power word and the exp word in s_tdata, end-of-vector in s_tlast.
// One result leaves on m_*: m_tuser is the accept flag, m_tdata the sample
// (zero when rejected), m_tlast the end mark of an accepted attempt.
// On reject, resend a request with the same offset.
// A request scans the table and divides by 961 before the exp(-r) series:
// 20 Horner terms, each one pass through the shared 32x32 multiplier
// (4 partial products) and the shared divider (4 bits a cycle).
// s_tready is high only when idle. A finished result waits in the output
// register while m_tready is low; the next request can be accepted then,
// and its result holds until the register drains.
// Reset clears log2_spread, the sequencer and m_tvalid.
module discrete_gaussian_sampler #(
  parameter int EXP_FRACTION_BITS = 53
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [4:0]                cfg_wdata,  // log2_spread
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [23:0] offset_bits, [24] sign_choice, [88:25] cdt_rand_high,
  // [152:89] cdt_rand_low, [216:153] power_rand, [269:217] exp_rand
  input  logic [dgs_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tlast,    // last_element
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [dgs_pkg::OUT_W-1:0] m_tdata,    // [29:0] sample_value
  output logic                      m_tuser,    // accepted
  output logic                      m_tlast     // last_sample
);
  import dgs_pkg::*;

  localparam int          TSH   = 62 - EXP_FRACTION_BITS;
  localparam logic [63:0] FMASK = (64'd1 << EXP_FRACTION_BITS) - 64'd1;

  state_t state;
  logic   issued;
  logic [4:0]  log2_spread, lsp;
  logic [23:0] urand;
  logic        sgn, lastr;
  logic [127:0] rnd;
  logic [63:0]  pwr;
  logic [52:0]  erand;
  logic [4:0]   z, nterm;
  logic [5:0]   u;
  logic [63:0]  r, p;

  logic         mul_go, mul_done, div_go, div_done;
  logic [63:0]  mul_a, mul_b, quot;
  logic [127:0] prod, dividend;
  logic [9:0]   divisor;
  logic [5:0]   steps;

  logic [30:0]  kmag, d;
  logic [29:0]  ad;
  logic [63:0]  zzsh, n, n200, thr, pmask;
  logic [5:0]   sh;
  logic         cdt_lt, pass;

  assign lsp = (log2_spread > 5'(MAX_SPREAD)) ? 5'(MAX_SPREAD) : log2_spread;
  assign s_tready = (state == ST_IDLE);

  // candidate d = k*2^L - offset
  assign kmag = (sgn ? 31'(z) + 31'd1 : 31'(z)) << lsp;
  assign d    = (sgn ? kmag : -kmag) - 31'(urand);
  assign ad   = d[30] ? 30'(-d) : d[29:0];
  assign zzsh = 64'(10'(z) * 10'(z)) << {lsp, 1'b0};
  assign n    = prod[63:0] - zzsh;
  assign n200 = (n << 7) + (n << 6) + (n << 3);
  assign sh   = {lsp, 1'b0} + 6'd2;
  assign cdt_lt = rnd < cdt_entry(z);

  assign thr   = p >> TSH;
  assign pmask = ~(64'hFFFF_FFFF_FFFF_FFFF << u);
  assign pass  = ((pwr & pmask) == 64'd0) && ((64'(erand) & FMASK) < thr);

  always_comb begin
    mul_go   = 1'b0;
    div_go   = 1'b0;
    mul_a    = r;
    mul_b    = p;
    dividend = {prod[125:62], 64'd0};
    divisor  = 10'(nterm);
    steps    = 6'd16;
    case (state)
      ST_SQ: begin
        mul_go = !issued;
        mul_a  = 64'(ad);
        mul_b  = 64'(ad);
      end
      ST_LOG: begin
        mul_go = !issued;
        mul_a  = n200;
        mul_b  = LOG2E_Q60;
      end
      ST_DIV: begin
        div_go   = !issued;
        dividend = prod >> sh;
        divisor  = DIV_961;
        steps    = 6'd32;
      end
      ST_LN2: begin
        mul_go = !issued;
        mul_a  = {2'b00, quot[57:0], 4'b0000};
        mul_b  = LN2_Q64;
      end
      ST_EXPM: mul_go = !issued;
      ST_EXPD: div_go = !issued;
      default: ;
    endcase
  end

  dgs_mul u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b),
    .prod(prod), .done(mul_done)
  );

  dgs_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(dividend),
    .divisor(divisor), .steps(steps), .quot(quot), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issued      <= 1'b0;
      log2_spread <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) log2_spread <= cfg_wdata;
      if (mul_done || div_done) issued <= 1'b0;
      else if (mul_go || div_go) issued <= 1'b1;
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (s_tvalid) state <= ST_CDT;
        ST_CDT:  if (!(z < 5'd20 && cdt_lt)) state <= ST_SQ;
        ST_SQ:   if (mul_done) state <= ST_LOG;
        ST_LOG:  if (mul_done) state <= ST_DIV;
        ST_DIV:  if (div_done) state <= ST_LN2;
        ST_LN2:  if (mul_done) state <= ST_EXPM;
        ST_EXPM: if (mul_done) state <= ST_EXPD;
        ST_EXPD: if (div_done) state <= (nterm == 5'd1) ? ST_OUT : ST_EXPM;
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      urand <= s_tdata[23:0] & ~(24'hFF_FFFF << lsp);
      sgn   <= s_tdata[24];
      rnd   <= {s_tdata[88:25], s_tdata[152:89]};
      pwr   <= s_tdata[216:153];
      erand <= s_tdata[269:217];
      lastr <= s_tlast;
      z     <= '0;
    end
    if (state == ST_CDT && z < 5'd20 && cdt_lt) z <= z + 5'd1;
    if (state == ST_DIV && div_done) u <= quot[63:58];
    if (state == ST_LN2 && mul_done) begin
      r     <= prod[127:64];
      p     <= ONE_Q62;
      nterm <= 5'(EXP_TERMS);
    end
    if (state == ST_EXPD && div_done) begin
      p     <= ONE_Q62 - quot;
      nterm <= nterm - 5'd1;
    end
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= pass;
      m_tdata <= pass ? {2'b00, d[29:0]} : '0;
      m_tlast <= pass & lastr;
    end
  end
endmodule

FILE: src/dgs_checker.sv
// Port-level checks for the discrete Gaussian sampler, bound to the top.
// Uses assert_macros.svh and dgs_pkg.
`include "assert_macros.svh"
module dgs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [dgs_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser,
  input logic                      m_tlast
);
  // a rejected attempt carries no sample and no end mark
  `DGS_ASSERT_NOW(a_reject_clear, m_tvalid && !m_tuser, m_tdata == '0 && !m_tlast)
  // one request at a time: busy right after taking one
  `DGS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
  `DGS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `DGS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
endmodule

bind discrete_gaussian_sampler dgs_checker u_dgs_checker (.*);
